[sv/rmp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared widths, register indexes and divider stage type for the reactive
// mask pixel pipeline.
// ----------------------------------------------------------------------------
package rmp_pkg;

    localparam int COMP_W = 16;
    localparam int CHAN_N = 3;
    localparam int NUM_W  = 18;   // sum of three 17-bit magnitudes
    localparam int DEN_W  = 17;   // floor plus three 16-bit magnitudes
    localparam int DVS_W  = 24;   // common divisor width of both dividers
    localparam int Q_W    = 17;   // Q0.16 with room for 1.0
    localparam int FRAC_W = 16;
    localparam int SIDE_W = 18;
    localparam int DIV_STAGES = FRAC_W + 1;

    localparam logic [Q_W-1:0]   UNIT_Q16 = 17'h10000;
    localparam logic [DVS_W-1:0] KNEE_ONE = 24'h010000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LUMINANCE_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REACTIVE_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_EPSILON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMPOSITION_KNEE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPOSITION_SCALE = 3'd4;

    typedef struct packed {
        logic [DVS_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs;
        logic [FRAC_W-1:0] quo;
        logic              sat;
        logic [SIDE_W-1:0] side;
    } div_stage_t;

endpackage
`default_nettype wire

[sv/rmp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_front
// Per-channel absolute differences and magnitudes, summed into the
// numerator and the floored denominator of the relative change.
// ----------------------------------------------------------------------------
module rmp_front (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [rmp_pkg::CHAN_N*rmp_pkg::COMP_W-1:0] opaque,
    input  wire logic [rmp_pkg::CHAN_N*rmp_pkg::COMP_W-1:0] final_c,
    input  wire logic [14:0]                             luminance_floor,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [rmp_pkg::NUM_W-1:0]                    num,
    output logic [rmp_pkg::DEN_W-1:0]                    den
);

    logic                       valid_reg;
    logic [rmp_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [rmp_pkg::DEN_W-1:0]  den_reg, den_next;

    always_comb begin
        logic signed [rmp_pkg::COMP_W:0] o, f, d;
        logic [rmp_pkg::COMP_W:0]        mo, mf, md;
        num_next = '0;
        den_next = (luminance_floor == 15'd0) ? rmp_pkg::DEN_W'(1)
                                              : rmp_pkg::DEN_W'(luminance_floor);
        for (int c = 0; c < rmp_pkg::CHAN_N; c++) begin
            o  = {opaque[c*rmp_pkg::COMP_W + rmp_pkg::COMP_W-1],
                  opaque[c*rmp_pkg::COMP_W +: rmp_pkg::COMP_W]};
            f  = {final_c[c*rmp_pkg::COMP_W + rmp_pkg::COMP_W-1],
                  final_c[c*rmp_pkg::COMP_W +: rmp_pkg::COMP_W]};
            d  = f - o;
            mo = o[rmp_pkg::COMP_W] ? $unsigned(-o) : $unsigned(o);
            mf = f[rmp_pkg::COMP_W] ? $unsigned(-f) : $unsigned(f);
            md = d[rmp_pkg::COMP_W] ? $unsigned(-d) : $unsigned(d);
            num_next = num_next + rmp_pkg::NUM_W'(md);
            den_next = den_next + rmp_pkg::DEN_W'((mo > mf) ? mo : mf);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign out_valid = valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule
`default_nettype wire

[sv/rmp_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_div
// Pipelined restoring divider: floor(a * 65536 / b) clamped to 1.0, one
// quotient bit per stage, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module rmp_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [rmp_pkg::DVS_W-1:0]    dividend,
    input  wire logic [rmp_pkg::DVS_W-1:0]    divisor,
    input  wire logic [rmp_pkg::SIDE_W-1:0]   side_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [rmp_pkg::Q_W-1:0]           quotient,
    output logic [rmp_pkg::SIDE_W-1:0]        side_out
);

    localparam int N = rmp_pkg::DIV_STAGES;

    logic                 valid_reg [N];
    rmp_pkg::div_stage_t  stage_reg [N];
    rmp_pkg::div_stage_t  stage_next [N];
    logic [N:0]           rdy;

    // stage may load when empty or when its content moves on
    always_comb begin
        rdy[N] = out_ready;
        for (int k = N-1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        logic [rmp_pkg::DVS_W:0] rem2;
        logic                    ge;
        stage_next[0].rem  = dividend;
        stage_next[0].dvs  = divisor;
        stage_next[0].quo  = '0;
        stage_next[0].sat  = (dividend >= divisor);
        stage_next[0].side = side_in;
        for (int k = 1; k < N; k++) begin
            rem2 = {stage_reg[k-1].rem, 1'b0};
            ge   = (rem2 >= {1'b0, stage_reg[k-1].dvs});
            stage_next[k]      = stage_reg[k-1];
            stage_next[k].rem  = ge ? rmp_pkg::DVS_W'(rem2 - {1'b0, stage_reg[k-1].dvs})
                                    : rem2[rmp_pkg::DVS_W-1:0];
            stage_next[k].quo  = {stage_reg[k-1].quo[rmp_pkg::FRAC_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) valid_reg[k] <= 1'b0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < N; k++) begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (rdy[k]) stage_reg[k] <= stage_next[k];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[N-1];
    assign quotient  = stage_reg[N-1].sat ? rmp_pkg::UNIT_Q16
                                          : {1'b0, stage_reg[N-1].quo};
    assign side_out  = stage_reg[N-1].side;

endmodule
`default_nettype wire

[sv/rmp_gain.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmp_gain
// One registered stage: y = min(1.0, x * g / 65536), x and side passed on.
// ----------------------------------------------------------------------------
module rmp_gain (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [rmp_pkg::Q_W-1:0]      x_in,
    input  wire logic [rmp_pkg::Q_W-1:0]      gain,
    input  wire logic [rmp_pkg::SIDE_W-1:0]   side_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [rmp_pkg::Q_W-1:0]           x_out,
    output logic [rmp_pkg::Q_W-1:0]           y_out,
    output logic [rmp_pkg::SIDE_W-1:0]        side_out
);

    logic                           valid_reg;
    logic [rmp_pkg::Q_W-1:0]        x_reg, y_reg, y_next;
    logic [rmp_pkg::SIDE_W-1:0]     side_reg;
    logic [2*rmp_pkg::Q_W-1:0]      prod;

    assign prod   = x_in * gain;
    assign y_next = (prod[2*rmp_pkg::Q_W-1:2*rmp_pkg::Q_W-2] != 2'b00)
                  ? rmp_pkg::UNIT_Q16
                  : prod[rmp_pkg::FRAC_W +: rmp_pkg::Q_W];

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x_reg    <= x_in;
            y_reg    <= y_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign side_out  = side_reg;

endmodule
`default_nettype wire

[sv/reactive_mask_pixel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// reactive_mask_pixel
// Reactive and composition mask values from an opaque and a final pixel.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | s_tdata: six signed Q8.8 components
//  m_       | out | m_tvalid/m_tready  | m_tdata: reactive, composition Q0.16
//  cfg_     | in  | cfg_we             | cfg_index, cfg_wdata
//
// One pixel per cycle while m_tready stays high. Stages: sum stage, 17-stage
// relative-change divider, gain stage, 17-stage knee divider, gain stage.
// Every stage has its own valid bit and loads when empty or draining, so a
// stall on m_ fills bubbles before it backs up to s_tready.
// aresetn is synchronous: it clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module reactive_mask_pixel (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // opaque_red, opaque_green, opaque_blue, final_red, final_green, final_blue
    input  wire logic [95:0]                        s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // reactive [16:0], composition [33:17], zero fill [39:34]
    output logic [39:0]                             m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [rmp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [14:0] floor_reg;
    logic [16:0] rscale_reg, eps_reg, cscale_reg;
    logic [23:0] knee_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg  <= 15'd13;
            rscale_reg <= 17'd32768;
            eps_reg    <= 17'd0;
            knee_reg   <= 24'd65536;
            cscale_reg <= 17'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rmp_pkg::REG_LUMINANCE_FLOOR:   floor_reg  <= cfg_wdata[14:0];
                rmp_pkg::REG_REACTIVE_SCALE:    rscale_reg <= cfg_wdata[16:0];
                rmp_pkg::REG_CHANGE_EPSILON:    eps_reg    <= cfg_wdata[16:0];
                rmp_pkg::REG_COMPOSITION_KNEE:  knee_reg   <= cfg_wdata[23:0];
                rmp_pkg::REG_COMPOSITION_SCALE: cscale_reg <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    logic                         f_valid, f_ready;
    logic [rmp_pkg::NUM_W-1:0]    f_num;
    logic [rmp_pkg::DEN_W-1:0]    f_den;

    rmp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .opaque          (s_tdata[47:0]),
        .final_c         (s_tdata[95:48]),
        .luminance_floor (floor_reg),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .num             (f_num),
        .den             (f_den)
    );

    logic                          d1_valid, d1_ready;
    logic [rmp_pkg::Q_W-1:0]       rel;
    logic [rmp_pkg::SIDE_W-1:0]    d1_side;

    rmp_div u_div_rel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .dividend  (rmp_pkg::DVS_W'(f_num)),
        .divisor   (rmp_pkg::DVS_W'(f_den)),
        .side_in   ('0),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quotient  (rel),
        .side_out  (d1_side)
    );

    logic                          g1_valid, g1_ready;
    logic [rmp_pkg::Q_W-1:0]       g1_rel, g1_reactive;
    logic [rmp_pkg::SIDE_W-1:0]    g1_side;

    rmp_gain u_gain_reactive (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .x_in      (rel),
        .gain      (rscale_reg),
        .side_in   (d1_side),
        .out_valid (g1_valid),
        .out_ready (g1_ready),
        .x_out     (g1_rel),
        .y_out     (g1_reactive),
        .side_out  (g1_side)
    );

    logic [rmp_pkg::DVS_W-1:0]     knee_eff;
    logic [rmp_pkg::SIDE_W-1:0]    d2_side_in;
    logic                          d2_valid, d2_ready;
    logic [rmp_pkg::Q_W-1:0]       ratio;
    logic [rmp_pkg::SIDE_W-1:0]    d2_side;

    assign knee_eff   = (knee_reg == '0) ? rmp_pkg::KNEE_ONE : knee_reg;
    // above-epsilon flag rides on top of the reactive value
    assign d2_side_in = {(g1_rel > eps_reg), g1_reactive};

    rmp_div u_div_knee (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (g1_valid),
        .in_ready  (g1_ready),
        .dividend  (rmp_pkg::DVS_W'(g1_rel)),
        .divisor   (knee_eff),
        .side_in   (d2_side_in),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .quotient  (ratio),
        .side_out  (d2_side)
    );

    logic [rmp_pkg::Q_W-1:0]       g2_ratio, g2_comp;
    logic [rmp_pkg::SIDE_W-1:0]    g2_side;

    rmp_gain u_gain_comp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .x_in      (ratio),
        .gain      (cscale_reg),
        .side_in   (d2_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .x_out     (g2_ratio),
        .y_out     (g2_comp),
        .side_out  (g2_side)
    );

    logic [rmp_pkg::Q_W-1:0] composition;
    logic                    unused_ok;

    assign composition = g2_side[rmp_pkg::SIDE_W-1] ? g2_comp : '0;
    assign m_tdata     = {6'd0, composition, g2_side[rmp_pkg::Q_W-1:0]};
    assign unused_ok   = ^{g2_ratio, g1_side};

endmodule
`default_nettype wire
